### rtl/core/hvlm_pkg.sv
package hvlm_pkg;

   // Largest number of samples counted into one block.
   localparam int MAX_BLOCK_SAMPLES = 2048;

   localparam int SAMPLE_W = 16;
   localparam int TICK_W   = 48;
   localparam int ENERGY_W = 42;
   localparam int LEVEL_W  = 15;
   localparam int SPAN_W   = 26;
   localparam int SQ_W     = 2 * SAMPLE_W - 1;
   localparam int LVL_SQ_W = 2 * LEVEL_W;
   localparam int COUNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int LIM_W    = LVL_SQ_W + COUNT_W;
   localparam int CMP_W    = (LIM_W > ENERGY_W) ? LIM_W : ENERGY_W;

   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = SPAN_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_VOICE_LEVEL   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_HOWL_LEVEL    = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] REG_SUSTAIN_TICKS = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] REG_MUTE_TICKS    = CSR_ADDR_W'(3);

   localparam logic [LEVEL_W-1:0] VOICE_LEVEL_RESET   = LEVEL_W'(184);
   localparam logic [LEVEL_W-1:0] HOWL_LEVEL_RESET    = LEVEL_W'(9175);
   localparam logic [SPAN_W-1:0]  SUSTAIN_TICKS_RESET = SPAN_W'(400000);
   localparam logic [SPAN_W-1:0]  MUTE_TICKS_RESET    = SPAN_W'(1500000);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_VOICE_SQ,
      ST_VOICE_MUL,
      ST_VOICE_CMP,
      ST_HOWL_SQ,
      ST_HOWL_MUL,
      ST_HOWL_CMP,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic in_ready;
      logic accum;
      logic lvl_square;
      logic sel_howl;
      logic lvl_mul;
      logic cmp_voice;
      logic cmp_howl;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic accepted;
      logic last;
      logic out_free;
   } status_type;

endpackage

### rtl/core/hvlm_if.sv
interface hvlm_req_if import hvlm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_in_block;
   logic [TICK_W-1:0]          now_ticks;

   modport source (output valid, sample, last_in_block, now_ticks, input ready);
   modport sink (input valid, sample, last_in_block, now_ticks, output ready);
endinterface

interface hvlm_rsp_if import hvlm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                send_block;
   logic                voice_seen;
   logic                howl_trip;
   logic [ENERGY_W-1:0] block_energy;
   logic [TICK_W-1:0]   last_voice_time;

   modport source (output valid, send_block, voice_seen, howl_trip, block_energy,
                   last_voice_time, input ready);
   modport sink (input valid, send_block, voice_seen, howl_trip, block_energy,
                 last_voice_time, output ready);
endinterface

interface hvlm_csr_if import hvlm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/howling_and_voice_level_monitor.sv
// Block level monitor for interleaved Q1.15 audio. Each sample item is squared on
// acceptance and added to a saturating block energy in the next cycle. For the
// marked last sample of a block, the voice and howl levels are then squared and
// multiplied by the sample count one after the other, sharing one squarer and one
// multiplier, compared with the energy, and the mute decision is made; one result
// item follows per block. Input is taken only while no item is in work.
// A result waits in an output register, and a following block end holds in its
// decision step until the register is taken. Configuration writes are accepted in
// every cycle and must only be issued while the block is idle.
module howling_and_voice_level_monitor import hvlm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hvlm_req_if.sink   req_chan,
   hvlm_rsp_if.source rsp_chan,
   hvlm_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;

   hvlm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   hvlm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

### rtl/core/hvlm_ctrl.sv
module hvlm_ctrl import hvlm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.accepted) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.last ? ST_VOICE_SQ : ST_IDLE;
         end
         ST_VOICE_SQ: begin
            cmd.lvl_square = 1'b1;
            state_in       = ST_VOICE_MUL;
         end
         ST_VOICE_MUL: begin
            cmd.lvl_mul = 1'b1;
            state_in    = ST_VOICE_CMP;
         end
         ST_VOICE_CMP: begin
            cmd.cmp_voice = 1'b1;
            state_in      = ST_HOWL_SQ;
         end
         ST_HOWL_SQ: begin
            cmd.lvl_square = 1'b1;
            cmd.sel_howl   = 1'b1;
            state_in       = ST_HOWL_MUL;
         end
         ST_HOWL_MUL: begin
            cmd.lvl_mul = 1'b1;
            state_in    = ST_HOWL_CMP;
         end
         ST_HOWL_CMP: begin
            cmd.cmp_howl = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            // The result waits here until the output register is free.
            if (status.out_free) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/hvlm_datapath.sv
module hvlm_datapath import hvlm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hvlm_req_if.sink   req_chan,
   hvlm_rsp_if.source rsp_chan,
   hvlm_csr_if.sink   csr_chan,
   input  cmd_type    cmd,
   output status_type status
);

   // Configuration registers.
   logic [LEVEL_W-1:0] voice_level_ff;
   logic [LEVEL_W-1:0] howl_level_ff;
   logic [SPAN_W-1:0]  sustain_ff;
   logic [SPAN_W-1:0]  mute_ticks_ff;

   // Block and tracking state.
   logic [ENERGY_W-1:0] energy_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                loud_active_ff;
   logic [TICK_W-1:0]   loud_since_ff;
   logic [TICK_W-1:0]   mute_until_ff;
   logic [TICK_W-1:0]   voice_time_ff;

   // Working registers of the current item.
   logic [SQ_W-1:0]     sq_ff;
   logic                last_ff;
   logic [TICK_W-1:0]   now_ff;
   logic [LVL_SQ_W-1:0] lvl_sq_ff;
   logic [LIM_W-1:0]    lim_ff;
   logic                voice_ff;
   logic                loud_ff;
   logic                muted_ff;
   logic                sustained_ff;
   logic [TICK_W-1:0]   end_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic                send_ff;
   logic                seen_ff;
   logic                trip_ff;
   logic [ENERGY_W-1:0] out_energy_ff;
   logic [TICK_W-1:0]   out_voice_ff;

   logic                  accepted;
   logic [SAMPLE_W-1:0]   raw;
   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] sq_full;
   logic [ENERGY_W:0]     sum;
   logic [LEVEL_W-1:0]    level;
   logic [LVL_SQ_W-1:0]   lvl_sq_in;
   logic [LIM_W-1:0]      lim_in;
   logic                  above;
   logic [TICK_W-1:0]     held;
   logic [TICK_W:0]       end_sum;
   logic                  send;
   logic                  trip;
   logic                  loud_active_in;
   logic [TICK_W-1:0]     loud_since_in;
   logic [TICK_W-1:0]     mute_until_in;
   logic [TICK_W-1:0]     voice_time_in;

   assign req_chan.ready = cmd.in_ready;
   assign csr_chan.ready = 1'b1;
   assign accepted       = req_chan.valid && cmd.in_ready;

   assign status.accepted = accepted;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.send_block      = send_ff;
   assign rsp_chan.voice_seen      = seen_ff;
   assign rsp_chan.howl_trip       = trip_ff;
   assign rsp_chan.block_energy    = out_energy_ff;
   assign rsp_chan.last_voice_time = out_voice_ff;

   // Magnitude of a two's complement sample; the most negative code maps to 2^15.
   assign raw     = req_chan.sample;
   assign mag     = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
   assign sq_full = mag * mag;

   assign sum       = (ENERGY_W+1)'(energy_ff) + (ENERGY_W+1)'(sq_ff);
   assign level     = cmd.sel_howl ? howl_level_ff : voice_level_ff;
   assign lvl_sq_in = level * level;
   assign lim_in    = lvl_sq_ff * count_ff;
   assign above     = CMP_W'(energy_ff) > CMP_W'(lim_ff);
   assign held      = now_ff - loud_since_ff;
   assign end_sum   = (TICK_W+1)'(now_ff) + (TICK_W+1)'(mute_ticks_ff);

   always_comb begin
      send           = 1'b1;
      trip           = 1'b0;
      loud_active_in = loud_active_ff;
      loud_since_in  = loud_since_ff;
      mute_until_in  = mute_until_ff;
      voice_time_in  = voice_ff ? now_ff : voice_time_ff;
      priority if (muted_ff) begin
         send = 1'b0;
      end else if (loud_ff) begin
         if (!loud_active_ff) begin
            loud_active_in = 1'b1;
            loud_since_in  = now_ff;
         end else if (sustained_ff) begin
            mute_until_in  = end_ff;
            loud_active_in = 1'b0;
            send           = 1'b0;
            trip           = 1'b1;
         end
      end else begin
         loud_active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_level_ff <= VOICE_LEVEL_RESET;
         howl_level_ff  <= HOWL_LEVEL_RESET;
         sustain_ff     <= SUSTAIN_TICKS_RESET;
         mute_ticks_ff  <= MUTE_TICKS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_VOICE_LEVEL:   voice_level_ff <= csr_chan.data[LEVEL_W-1:0];
            REG_HOWL_LEVEL:    howl_level_ff  <= csr_chan.data[LEVEL_W-1:0];
            REG_SUSTAIN_TICKS: sustain_ff     <= csr_chan.data[SPAN_W-1:0];
            REG_MUTE_TICKS:    mute_ticks_ff  <= csr_chan.data[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff      <= '0;
         count_ff       <= '0;
         loud_active_ff <= 1'b0;
         loud_since_ff  <= '0;
         mute_until_ff  <= '0;
         voice_time_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // Samples past the block store add neither count nor energy.
         if (cmd.accum && (count_ff < COUNT_W'(MAX_BLOCK_SAMPLES))) begin
            count_ff  <= count_ff + COUNT_W'(1);
            energy_ff <= sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
         end
         if (cmd.decide) begin
            energy_ff      <= '0;
            count_ff       <= '0;
            loud_active_ff <= loud_active_in;
            loud_since_ff  <= loud_since_in;
            mute_until_ff  <= mute_until_in;
            voice_time_ff  <= voice_time_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accepted) begin
         sq_ff   <= sq_full[SQ_W-1:0];
         last_ff <= req_chan.last_in_block;
         now_ff  <= req_chan.now_ticks;
      end
      if (cmd.lvl_square) begin
         lvl_sq_ff <= lvl_sq_in;
      end
      if (cmd.lvl_mul) begin
         lim_ff <= lim_in;
      end
      if (cmd.cmp_voice) begin
         voice_ff <= above;
      end
      if (cmd.cmp_howl) begin
         loud_ff <= above;
      end
      // The time checks settle during the level sequence, well before the decision.
      muted_ff     <= now_ff < mute_until_ff;
      sustained_ff <= held > TICK_W'(sustain_ff);
      end_ff       <= end_sum[TICK_W] ? {TICK_W{1'b1}} : end_sum[TICK_W-1:0];
      if (cmd.decide) begin
         send_ff       <= send;
         seen_ff       <= voice_ff;
         trip_ff       <= trip;
         out_energy_ff <= energy_ff;
         out_voice_ff  <= voice_time_in;
      end
   end

endmodule
